// ----- rtl/wppt_pkg.sv -----
package wppt_pkg;

   // Fixed field widths of the transaction payloads.
   localparam int SAMPLE_BITS = 10;
   localparam int TIME_BITS = 32;
   localparam int CSR_INDEX_BITS = 8;
   localparam int CSR_DATA_BITS = 32;

   // Default depth of the sample window memory.
   localparam int MAX_WINDOW_DEFAULT = 64;

   // Age counters saturate here.
   localparam int AGE_SAT = 127;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_SIZE = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPIKE_HEIGHT = 8'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_INTERVAL = 8'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FIRST_FREE = 8'd3;

   // Configuration reset values.
   localparam logic [6:0] RST_WINDOW_SIZE = 7'd45;
   localparam logic [9:0] RST_SPIKE_HEIGHT = 10'd15;
   localparam logic [15:0] RST_MIN_INTERVAL = 16'd600;
   localparam logic RST_FIRST_FREE = 1'b0;

   // Microprogram step addresses.
   localparam int STEP_BITS = 4;
   localparam logic [STEP_BITS-1:0] ST_IDLE = 4'd0;
   localparam logic [STEP_BITS-1:0] ST_MOD = 4'd1;
   localparam logic [STEP_BITS-1:0] ST_WRITE = 4'd2;
   localparam logic [STEP_BITS-1:0] ST_CHKMAX = 4'd3;
   localparam logic [STEP_BITS-1:0] ST_CHKMIN = 4'd4;
   localparam logic [STEP_BITS-1:0] ST_SETUP = 4'd5;
   localparam logic [STEP_BITS-1:0] ST_FIRST = 4'd6;
   localparam logic [STEP_BITS-1:0] ST_LOOP = 4'd7;
   localparam logic [STEP_BITS-1:0] ST_DONE = 4'd8;
   localparam logic [STEP_BITS-1:0] ST_TRIG = 4'd9;

   // Datapath operations.
   localparam logic [3:0] OP_ACCEPT = 4'd0;
   localparam logic [3:0] OP_MOD = 4'd1;
   localparam logic [3:0] OP_WRITE = 4'd2;
   localparam logic [3:0] OP_SEL_MAX = 4'd3;
   localparam logic [3:0] OP_SEL_MIN = 4'd4;
   localparam logic [3:0] OP_SETUP = 4'd5;
   localparam logic [3:0] OP_FIRST = 4'd6;
   localparam logic [3:0] OP_LOOP = 4'd7;
   localparam logic [3:0] OP_DONE = 4'd8;
   localparam logic [3:0] OP_TRIG = 4'd9;

   // Branch conditions.
   localparam logic [2:0] CND_ALWAYS = 3'd0;
   localparam logic [2:0] CND_REQ_VALID = 3'd1;
   localparam logic [2:0] CND_MOD_DONE = 3'd2;
   localparam logic [2:0] CND_MAX_STALE = 3'd3;
   localparam logic [2:0] CND_MIN_STALE = 3'd4;
   localparam logic [2:0] CND_SEARCH_END = 3'd5;
   localparam logic [2:0] CND_MODE_MAX = 3'd6;
   localparam logic [2:0] CND_OUT_FREE = 3'd7;

   // One control word: an operation and a two-way branch.
   typedef struct packed {
      logic [3:0] op;
      logic [2:0] cond;
      logic [STEP_BITS-1:0] tgt_true;
      logic [STEP_BITS-1:0] tgt_false;
   } ctrl_word_type;

   // Status flags from the datapath that the branches test.
   typedef struct packed {
      logic mod_done;
      logic max_stale;
      logic min_stale;
      logic search_end;
      logic mode_max;
      logic out_free;
   } seq_status_type;

   // Control store.
   function automatic ctrl_word_type ucode_rom(input logic [STEP_BITS-1:0] step);
      ctrl_word_type word;
      case (step)
         ST_IDLE: word = '{OP_ACCEPT, CND_REQ_VALID, ST_MOD, ST_IDLE};
         ST_MOD: word = '{OP_MOD, CND_MOD_DONE, ST_WRITE, ST_MOD};
         ST_WRITE: word = '{OP_WRITE, CND_ALWAYS, ST_CHKMAX, ST_CHKMAX};
         ST_CHKMAX: word = '{OP_SEL_MAX, CND_MAX_STALE, ST_SETUP, ST_CHKMIN};
         ST_CHKMIN: word = '{OP_SEL_MIN, CND_MIN_STALE, ST_SETUP, ST_TRIG};
         ST_SETUP: word = '{OP_SETUP, CND_ALWAYS, ST_FIRST, ST_FIRST};
         ST_FIRST: word = '{OP_FIRST, CND_SEARCH_END, ST_DONE, ST_LOOP};
         ST_LOOP: word = '{OP_LOOP, CND_SEARCH_END, ST_DONE, ST_LOOP};
         ST_DONE: word = '{OP_DONE, CND_MODE_MAX, ST_CHKMIN, ST_TRIG};
         ST_TRIG: word = '{OP_TRIG, CND_OUT_FREE, ST_IDLE, ST_TRIG};
         default: word = '{OP_ACCEPT, CND_ALWAYS, ST_IDLE, ST_IDLE};
      endcase
      return word;
   endfunction

endpackage

// ----- rtl/window_peak_to_peak_trigger_unit.sv -----
// Channel         Direction  Signals
// input samples   in         req_valid/req_ready, req_sample, req_timestamp, req_motor_on
// results         out        rsp_valid/rsp_ready, rsp_sample_out, rsp_trigger,
//                            rsp_window_min, rsp_window_max
// configuration   in         csr_valid/csr_ready, csr_index, csr_data
//
// A transaction takes extra subtraction steps when the window was shortened below the
// slot. Each extreme that ages out starts a re-search that walks the window memory
// one entry per cycle through its single read port.
// Reset is synchronous and needs no clearing pass: per-entry valid bits make the window
// read as zero. Both ready outputs stay low while reset is held.
// A stalled result holds the sequencer in its last step; input is taken
// again only once the previous result has been moved into the output register.
module window_peak_to_peak_trigger_unit
   import wppt_pkg::*;
#(
   parameter int MAX_WINDOW = MAX_WINDOW_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [SAMPLE_BITS-1:0]    req_sample,
   input  logic [TIME_BITS-1:0]      req_timestamp,
   input  logic                      req_motor_on,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [SAMPLE_BITS-1:0]    rsp_sample_out,
   output logic                      rsp_trigger,
   output logic [SAMPLE_BITS-1:0]    rsp_window_min,
   output logic [SAMPLE_BITS-1:0]    rsp_window_max,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

   ctrl_word_type          ctrl;
   seq_status_type         status;
   logic                   mem_wr_en;
   logic [AW-1:0]          mem_wr_addr;
   logic [SAMPLE_BITS-1:0] mem_wr_data;
   logic [AW-1:0]          mem_rd_addr;
   logic [SAMPLE_BITS-1:0] mem_rd_data;

   // Control store and step counter.
   wppt_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .ctrl      (ctrl)
   );

   // Registers, comparators and the handshakes.
   wppt_datapath #(
      .MAX_WINDOW (MAX_WINDOW),
      .AW         (AW)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (ctrl),
      .status         (status),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample     (req_sample),
      .req_timestamp  (req_timestamp),
      .req_motor_on   (req_motor_on),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .rsp_trigger    (rsp_trigger),
      .rsp_window_min (rsp_window_min),
      .rsp_window_max (rsp_window_max),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mem_wr_en      (mem_wr_en),
      .mem_wr_addr    (mem_wr_addr),
      .mem_wr_data    (mem_wr_data),
      .mem_rd_addr    (mem_rd_addr),
      .mem_rd_data    (mem_rd_data)
   );

   // Circular sample window.
   wppt_ram #(
      .DEPTH (MAX_WINDOW),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

// ----- rtl/wppt_ram.sv -----
module wppt_ram
   import wppt_pkg::*;
#(
   parameter int DEPTH = MAX_WINDOW_DEFAULT,
   parameter int AW = $clog2(MAX_WINDOW_DEFAULT)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  logic [AW-1:0]          wr_addr,
   input  logic [SAMPLE_BITS-1:0] wr_data,
   input  logic [AW-1:0]          rd_addr,
   output logic [SAMPLE_BITS-1:0] rd_data
);

   logic [SAMPLE_BITS-1:0] sample_mem [DEPTH];
   logic [DEPTH-1:0]       valid_ff;
   logic [SAMPLE_BITS-1:0] rdata_ff;
   logic                   rvalid_ff;

   // Storage array with a registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         sample_mem[wr_addr] <= wr_data;
      end
      rdata_ff <= sample_mem[rd_addr];
   end

   // Per-entry valid bits so that unwritten entries read as zero after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rvalid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rvalid_ff ? rdata_ff : '0;

endmodule

// ----- rtl/wppt_seq.sv -----
module wppt_seq
   import wppt_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  seq_status_type status,
   output ctrl_word_type  ctrl
);

   logic [STEP_BITS-1:0] step_ff;
   logic [STEP_BITS-1:0] step_in;
   logic                 cond_true;

   assign ctrl = ucode_rom(step_ff);

   // Evaluate the branch condition of the current control word.
   always_comb begin
      case (ctrl.cond)
         CND_ALWAYS: cond_true = 1'b1;
         CND_REQ_VALID: cond_true = req_valid;
         CND_MOD_DONE: cond_true = status.mod_done;
         CND_MAX_STALE: cond_true = status.max_stale;
         CND_MIN_STALE: cond_true = status.min_stale;
         CND_SEARCH_END: cond_true = status.search_end;
         CND_MODE_MAX: cond_true = status.mode_max;
         CND_OUT_FREE: cond_true = status.out_free;
         default: cond_true = 1'b0;
      endcase
      step_in = cond_true ? ctrl.tgt_true : ctrl.tgt_false;
   end

   // Step counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

// ----- rtl/wppt_datapath.sv -----
module wppt_datapath
   import wppt_pkg::*;
#(
   parameter int MAX_WINDOW = MAX_WINDOW_DEFAULT,
   parameter int AW = $clog2(MAX_WINDOW_DEFAULT)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ctrl_word_type             ctrl,
   output seq_status_type            status,
   // Input channel.
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [SAMPLE_BITS-1:0]    req_sample,
   input  logic [TIME_BITS-1:0]      req_timestamp,
   input  logic                      req_motor_on,
   // Result channel.
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [SAMPLE_BITS-1:0]    rsp_sample_out,
   output logic                      rsp_trigger,
   output logic [SAMPLE_BITS-1:0]    rsp_window_min,
   output logic [SAMPLE_BITS-1:0]    rsp_window_max,
   // Configuration channel.
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   // Window memory.
   output logic                      mem_wr_en,
   output logic [AW-1:0]             mem_wr_addr,
   output logic [SAMPLE_BITS-1:0]    mem_wr_data,
   output logic [AW-1:0]             mem_rd_addr,
   input  logic [SAMPLE_BITS-1:0]    mem_rd_data
);

   localparam int WW = $clog2(MAX_WINDOW + 1);
   localparam int AGW = (WW > 7) ? WW : 7;

   // Configuration registers.
   logic [6:0]  window_size_ff;
   logic [9:0]  spike_height_ff;
   logic [15:0] interval_ff;
   logic        first_free_ff;

   // Transaction being worked on.
   logic [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic [TIME_BITS-1:0]   ts_ff, ts_in;
   logic                   active_ff, active_in;

   // Tracker state.
   logic [AW-1:0]          slot_ff, slot_in;
   logic [WW-1:0]          mod_ff, mod_in;
   logic [SAMPLE_BITS-1:0] min_ff, min_in;
   logic [SAMPLE_BITS-1:0] max_ff, max_in;
   logic [AGW-1:0]         min_age_ff, min_age_in;
   logic [AGW-1:0]         max_age_ff, max_age_in;
   logic                   set_ff, set_in;
   logic [TIME_BITS-1:0]   last_ff, last_in;

   // Search state.
   logic                   mode_max_ff, mode_max_in;
   logic [AW-1:0]          ptr_ff, ptr_in;
   logic [WW-1:0]          cnt_ff, cnt_in;
   logic [SAMPLE_BITS-1:0] best_ff, best_in;
   logic [WW-1:0]          best_age_ff, best_age_in;

   // Output register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] out_sample_ff, out_sample_in;
   logic                   out_trig_ff, out_trig_in;
   logic [SAMPLE_BITS-1:0] out_min_ff, out_min_in;
   logic [SAMPLE_BITS-1:0] out_max_ff, out_max_in;

   logic [WW-1:0]        w_eff;
   logic [AW-1:0]        ptr_dec;
   logic                 out_free;
   logic                 better;
   logic                 trig;
   logic [TIME_BITS-1:0] dt;

   // Effective window length: zero acts as one, large values clamp to the depth.
   always_comb begin
      if (window_size_ff == 7'd0) begin
         w_eff = WW'(1);
      end else if (32'(window_size_ff) > 32'(MAX_WINDOW)) begin
         w_eff = WW'(MAX_WINDOW);
      end else begin
         w_eff = WW'(window_size_ff);
      end
   end

   assign ptr_dec = (ptr_ff == '0) ? AW'(w_eff - WW'(1)) : ptr_ff - AW'(1);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign better = mode_max_ff ? (mem_rd_data >= best_ff) : (mem_rd_data <= best_ff);
   assign dt = ts_ff - last_ff;
   assign trig = active_ff && (max_ff >= min_ff) && ((max_ff - min_ff) > spike_height_ff)
                 && (first_free_ff || (dt > TIME_BITS'(interval_ff)));

   // Flags for the sequencer.
   always_comb begin
      status.mod_done = mod_ff < w_eff;
      status.max_stale = max_age_ff >= AGW'(w_eff);
      status.min_stale = min_age_ff >= AGW'(w_eff);
      status.search_end = ((WW+1)'(cnt_ff) + (WW+1)'(1)) >= (WW+1)'(w_eff);
      status.mode_max = mode_max_ff;
      status.out_free = out_free;
   end

   // Nothing is taken on either input channel while reset is held.
   assign req_ready = !reset && (ctrl.op == OP_ACCEPT);
   assign csr_ready = !reset;

   assign mem_wr_en = ctrl.op == OP_WRITE;
   assign mem_wr_addr = slot_ff;
   assign mem_wr_data = sample_ff;
   assign mem_rd_addr = (ctrl.op == OP_SETUP) ? slot_ff : ptr_ff;

   // Operation decode for the current control word.
   always_comb begin
      sample_in = sample_ff;
      ts_in = ts_ff;
      active_in = active_ff;
      slot_in = slot_ff;
      mod_in = mod_ff;
      min_in = min_ff;
      max_in = max_ff;
      min_age_in = min_age_ff;
      max_age_in = max_age_ff;
      set_in = set_ff;
      last_in = last_ff;
      mode_max_in = mode_max_ff;
      ptr_in = ptr_ff;
      cnt_in = cnt_ff;
      best_in = best_ff;
      best_age_in = best_age_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      out_sample_in = out_sample_ff;
      out_trig_in = out_trig_ff;
      out_min_in = out_min_ff;
      out_max_in = out_max_ff;
      case (ctrl.op)
         OP_ACCEPT: begin
            if (req_valid) begin
               sample_in = req_sample;
               ts_in = req_timestamp;
               active_in = req_motor_on;
               mod_in = WW'(slot_ff) + WW'(1);
            end
         end
         OP_MOD: begin
            // Reduce the advanced slot modulo the window by repeated subtraction.
            if (mod_ff >= w_eff) begin
               mod_in = mod_ff - w_eff;
            end else begin
               slot_in = AW'(mod_ff);
            end
         end
         OP_WRITE: begin
            // The sample goes to memory; the running extremes follow it.
            if (!active_ff) begin
               set_in = 1'b0;
               min_in = '0;
               max_in = '0;
               min_age_in = '0;
               max_age_in = '0;
            end else if (!set_ff) begin
               set_in = 1'b1;
               min_in = sample_ff;
               max_in = sample_ff;
               min_age_in = '0;
               max_age_in = '0;
            end else begin
               if (sample_ff <= min_ff) begin
                  min_in = sample_ff;
                  min_age_in = '0;
               end else if (min_age_ff >= AGW'(AGE_SAT)) begin
                  min_age_in = AGW'(AGE_SAT);
               end else begin
                  min_age_in = min_age_ff + AGW'(1);
               end
               if (sample_ff >= max_ff) begin
                  max_in = sample_ff;
                  max_age_in = '0;
               end else if (max_age_ff >= AGW'(AGE_SAT)) begin
                  max_age_in = AGW'(AGE_SAT);
               end else begin
                  max_age_in = max_age_ff + AGW'(1);
               end
            end
         end
         OP_SEL_MAX: begin
            mode_max_in = 1'b1;
         end
         OP_SEL_MIN: begin
            mode_max_in = 1'b0;
         end
         OP_SETUP: begin
            // The newest entry is read now; the walk continues toward older ones.
            ptr_in = (slot_ff == '0) ? AW'(w_eff - WW'(1)) : slot_ff - AW'(1);
            cnt_in = '0;
         end
         OP_FIRST: begin
            best_in = mem_rd_data;
            best_age_in = '0;
            ptr_in = ptr_dec;
            cnt_in = WW'(1);
         end
         OP_LOOP: begin
            // Equal values replace the best, so ties go to the oldest entry.
            if (better) begin
               best_in = mem_rd_data;
               best_age_in = cnt_ff;
            end
            ptr_in = ptr_dec;
            cnt_in = cnt_ff + WW'(1);
         end
         OP_DONE: begin
            if (mode_max_ff) begin
               max_in = best_ff;
               max_age_in = AGW'(best_age_ff);
            end else begin
               min_in = best_ff;
               min_age_in = AGW'(best_age_ff);
            end
         end
         OP_TRIG: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_sample_in = sample_ff;
               out_trig_in = trig;
               out_min_in = min_ff;
               out_max_in = max_ff;
               if (trig) begin
                  last_in = ts_ff;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Control and tracker registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= RST_WINDOW_SIZE;
         spike_height_ff <= RST_SPIKE_HEIGHT;
         interval_ff <= RST_MIN_INTERVAL;
         first_free_ff <= RST_FIRST_FREE;
         slot_ff <= '0;
         min_ff <= '0;
         max_ff <= '0;
         min_age_ff <= '0;
         max_age_ff <= '0;
         set_ff <= 1'b0;
         last_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_WINDOW_SIZE: window_size_ff <= csr_data[6:0];
               CSR_SPIKE_HEIGHT: spike_height_ff <= csr_data[9:0];
               CSR_MIN_INTERVAL: interval_ff <= csr_data[15:0];
               CSR_FIRST_FREE: first_free_ff <= csr_data[0];
               default: begin
               end
            endcase
         end
         slot_ff <= slot_in;
         min_ff <= min_in;
         max_ff <= max_in;
         min_age_ff <= min_age_in;
         max_age_ff <= max_age_in;
         set_ff <= set_in;
         last_ff <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      ts_ff <= ts_in;
      active_ff <= active_in;
      mod_ff <= mod_in;
      mode_max_ff <= mode_max_in;
      ptr_ff <= ptr_in;
      cnt_ff <= cnt_in;
      best_ff <= best_in;
      best_age_ff <= best_age_in;
      out_sample_ff <= out_sample_in;
      out_trig_ff <= out_trig_in;
      out_min_ff <= out_min_in;
      out_max_ff <= out_max_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_sample_out = out_sample_ff;
   assign rsp_trigger = out_trig_ff;
   assign rsp_window_min = out_min_ff;
   assign rsp_window_max = out_max_ff;

endmodule

// ----- verif/window_peak_to_peak_trigger_unit_tb.sv -----
module window_peak_to_peak_trigger_unit_tb;
   import wppt_pkg::*;

   localparam int WIN_DEPTH = MAX_WINDOW_DEFAULT;
   // An index with no register behind it; a write there must change nothing.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_INDEX = 8'd4;

   // One result transaction as the block should report it.
   typedef struct packed {
      bit [SAMPLE_BITS-1:0] sample;
      bit                   fire;
      bit [SAMPLE_BITS-1:0] wmin;
      bit [SAMPLE_BITS-1:0] wmax;
   } peak_report_t;

   // Tracks the window extremes and trigger timing, and checks the block's reports.
   class peak_window_checker;
      bit [6:0]             window_size;
      bit [9:0]             spike_height;
      bit [15:0]            min_interval;
      bit                   first_free;
      bit [SAMPLE_BITS-1:0] window_mem [WIN_DEPTH];
      int unsigned          slot;
      bit [SAMPLE_BITS-1:0] lo_val;
      bit [SAMPLE_BITS-1:0] hi_val;
      int unsigned          lo_age;
      int unsigned          hi_age;
      bit                   tracking;
      bit [TIME_BITS-1:0]   last_fire;
      peak_report_t         awaited_reports [$];
      int                   mismatches;
      int                   samples_in;
      int                   reports_seen;
      int                   fires_seen;
      int                   rescans;

      function new();
         window_size = RST_WINDOW_SIZE;
         spike_height = RST_SPIKE_HEIGHT;
         min_interval = RST_MIN_INTERVAL;
         first_free = RST_FIRST_FREE;
         foreach (window_mem[i]) window_mem[i] = '0;
         slot = 0;
         lo_val = '0;
         hi_val = '0;
         lo_age = 0;
         hi_age = 0;
         tracking = 1'b0;
         last_fire = '0;
         mismatches = 0;
         samples_in = 0;
         reports_seen = 0;
         fires_seen = 0;
         rescans = 0;
      endfunction

      function void set_reg(bit [CSR_INDEX_BITS-1:0] idx, bit [CSR_DATA_BITS-1:0] data);
         case (idx)
            CSR_WINDOW_SIZE: window_size = data[6:0];
            CSR_SPIKE_HEIGHT: spike_height = data[9:0];
            CSR_MIN_INTERVAL: min_interval = data[15:0];
            CSR_FIRST_FREE: first_free = data[0];
            default: ;
         endcase
      endfunction

      // Effective window length: zero acts as one, oversize clips to the depth.
      function int unsigned span();
         if (window_size == 0) return 1;
         if (window_size > WIN_DEPTH) return WIN_DEPTH;
         return window_size;
      endfunction

      // Walk the window newest to oldest; on a tie the older entry wins.
      function void rescan(int unsigned w, bit want_hi, output bit [SAMPLE_BITS-1:0] val,
                           output int unsigned age);
         bit [SAMPLE_BITS-1:0] best;
         bit [SAMPLE_BITS-1:0] cur;
         int unsigned          best_age;
         int unsigned          j;
         best = window_mem[slot];
         best_age = 0;
         for (j = 1; j < w; j++) begin
            cur = window_mem[(slot + w - j) % w];
            if (want_hi ? (cur >= best) : (cur <= best)) begin
               best = cur;
               best_age = j;
            end
         end
         val = best;
         age = best_age;
         rescans++;
      endfunction

      // Work out the report for one accepted sample transaction.
      function void note_sample(bit [SAMPLE_BITS-1:0] s, bit [TIME_BITS-1:0] ts, bit on);
         int unsigned        w;
         bit                 fire;
         bit [TIME_BITS-1:0] dt;
         peak_report_t       rep;
         w = span();
         fire = 1'b0;
         slot = (slot + 1) % w;
         window_mem[slot] = s;
         samples_in++;
         if (on) begin
            if (!tracking) begin
               lo_val = s;
               hi_val = s;
               lo_age = 0;
               hi_age = 0;
               tracking = 1'b1;
            end else begin
               if (s <= lo_val) begin
                  lo_val = s;
                  lo_age = 0;
               end else begin
                  lo_age = (lo_age >= AGE_SAT) ? AGE_SAT : lo_age + 1;
               end
               if (s >= hi_val) begin
                  hi_val = s;
                  hi_age = 0;
               end else begin
                  hi_age = (hi_age >= AGE_SAT) ? AGE_SAT : hi_age + 1;
               end
            end
            if (hi_age >= w) rescan(w, 1'b1, hi_val, hi_age);
            if (lo_age >= w) rescan(w, 1'b0, lo_val, lo_age);
            if (hi_val >= lo_val && (hi_val - lo_val) > spike_height) begin
               dt = ts - last_fire;
               if (first_free || dt > {16'd0, min_interval}) begin
                  fire = 1'b1;
                  last_fire = ts;
               end
            end
         end else begin
            tracking = 1'b0;
            lo_val = '0;
            hi_val = '0;
            lo_age = 0;
            hi_age = 0;
         end
         rep.sample = s;
         rep.fire = fire;
         rep.wmin = lo_val;
         rep.wmax = hi_val;
         awaited_reports.push_back(rep);
      endfunction

      // Compare one accepted result transaction with the oldest awaited report.
      function void check_result(logic [SAMPLE_BITS-1:0] s, logic fire,
                                 logic [SAMPLE_BITS-1:0] wmin, logic [SAMPLE_BITS-1:0] wmax);
         peak_report_t rep;
         if (awaited_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("MISMATCH: unexpected result sample=%0d trigger=%0b min=%0d max=%0d",
                        s, fire, wmin, wmax);
            return;
         end
         rep = awaited_reports.pop_front();
         reports_seen++;
         if (fire === 1'b1) fires_seen++;
         if (s !== rep.sample || fire !== rep.fire || wmin !== rep.wmin ||
             wmax !== rep.wmax) begin
            mismatches++;
            if (mismatches <= 10)
               $display("MISMATCH at result %0d: expected sample=%0d trigger=%0b min=%0d max=%0d, got sample=%0d trigger=%0b min=%0d max=%0d",
                        reports_seen, rep.sample, rep.fire, rep.wmin, rep.wmax,
                        s, fire, wmin, wmax);
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [SAMPLE_BITS-1:0]    req_sample = '0;
   logic [TIME_BITS-1:0]      req_timestamp = '0;
   logic                      req_motor_on = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [SAMPLE_BITS-1:0]    rsp_sample_out;
   logic                      rsp_trigger;
   logic [SAMPLE_BITS-1:0]    rsp_window_min;
   logic [SAMPLE_BITS-1:0]    rsp_window_max;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   peak_window_checker sb;
   int                 send_idle_pct = 0;
   int                 recv_stall_pct = 0;
   logic               hold_rsp = 1'b0;
   int                 settings_used = 0;

   // Random sample source state.
   int                 base_level = 512;
   int                 prev_sample = 512;
   int                 off_left = 0;
   bit [TIME_BITS-1:0] now_ms = '0;

   window_peak_to_peak_trigger_unit uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_sample(req_sample),
      .req_timestamp(req_timestamp),
      .req_motor_on(req_motor_on),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_sample_out(rsp_sample_out),
      .rsp_trigger(rsp_trigger),
      .rsp_window_min(rsp_window_min),
      .rsp_window_max(rsp_window_max),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // Receiver: random stalls, or a long hold-off while hold_rsp is set.
   always @(posedge clock) begin
      rsp_ready <= !hold_rsp && ($urandom_range(99) >= recv_stall_pct);
   end

   // Result monitor.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_sample_out, rsp_trigger, rsp_window_min, rsp_window_max);
   end

   // Offer one sample transaction and hold it until accepted; valid stays high.
   task send_item(input bit [SAMPLE_BITS-1:0] s, input bit [TIME_BITS-1:0] ts, input bit on);
      req_valid <= 1'b1;
      req_sample <= s;
      req_timestamp <= ts;
      req_motor_on <= on;
      do @(posedge clock); while (!req_ready);
      sb.note_sample(s, ts, on);
   endtask

   // Sender idle gap between transactions.
   task sender_gap();
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   // Register write; csr_valid is left high for a following write.
   task write_csr(input logic [CSR_INDEX_BITS-1:0] idx, input logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, data);
   endtask

   // Wait until every awaited report has arrived, then let the block settle.
   task drain();
      req_valid <= 1'b0;
      while (sb.awaited_reports.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Reprogram all registers while the block is idle. Junk in the upper data bits
   // must be ignored.
   task apply_setting(input int ws, input int sh, input int iv, input int free,
                      input bit junk);
      logic [CSR_DATA_BITS-1:0] upper;
      upper = junk ? ($urandom & 32'hFFFF_0000) : '0;
      drain();
      write_csr(CSR_WINDOW_SIZE, upper | ws);
      write_csr(CSR_SPIKE_HEIGHT, upper | sh);
      write_csr(CSR_MIN_INTERVAL, upper | iv);
      write_csr(CSR_FIRST_FREE, upper | free);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // One random sample: mostly a noisy baseline with spikes, some full-range noise,
   // short motor-off stretches, and occasional timestamp jumps and wraps.
   task offer_random();
      int r;
      int s;
      bit on;
      r = $urandom_range(99);
      if (r < 2) base_level = $urandom_range(1023);
      else base_level = base_level + $urandom_range(16) - 8;
      if (base_level < 0) base_level = 0;
      if (base_level > 1023) base_level = 1023;
      r = $urandom_range(99);
      if (r < 45) s = base_level + $urandom_range(6) - 3;
      else if (r < 60) s = base_level;
      else if (r < 78) s = base_level + $urandom_range(700) - 350;
      else if (r < 90) s = $urandom_range(1023);
      else if (r < 95) s = (r % 2) ? 1023 : 0;
      else s = prev_sample;
      if (s < 0) s = 0;
      if (s > 1023) s = 1023;
      prev_sample = s;
      if (off_left > 0) begin
         on = 1'b0;
         off_left--;
      end else if ($urandom_range(99) < 3) begin
         on = 1'b0;
         off_left = $urandom_range(4);
      end else begin
         on = 1'b1;
      end
      r = $urandom_range(199);
      if (r == 0) now_ms = $urandom;
      else if (r == 1) now_ms = 32'hFFFF_FFFF - $urandom_range(50);
      else now_ms = now_ms + $urandom_range(60);
      sender_gap();
      send_item(s[SAMPLE_BITS-1:0], now_ms, on);
   endtask

   task run_phase(input int ws, input int sh, input int iv, input int free,
                  input int count, input int send_pct, input int recv_pct);
      apply_setting(ws, sh, iv, free, 1'b0);
      send_idle_pct = send_pct;
      recv_stall_pct <= recv_pct;
      repeat (count) offer_random();
   endtask

   initial begin
      #40_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      int waited;
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset settings, first active sample, field extremes, interval
      // boundary, timestamp wrap, and clearing on motor off.
      send_item(10'd0, 32'd0, 1'b1);
      send_item(10'd1023, 32'd100, 1'b1);
      send_item(10'd500, 32'd601, 1'b1);
      send_item(10'd500, 32'd1201, 1'b1);
      send_item(10'd500, 32'd1202, 1'b1);
      send_item(10'd1023, 32'hFFFF_FFFF, 1'b0);
      send_item(10'd512, 32'hFFFF_FFFF, 1'b1);
      send_item(10'd528, 32'd5, 1'b1);
      send_item(10'd527, 32'd10, 1'b1);

      // Directed: short window with ties, so stale extremes are searched again.
      apply_setting(3, 2, 0, 1, 1'b0);
      send_item(10'd5, 32'd20, 1'b1);
      send_item(10'd5, 32'd21, 1'b1);
      send_item(10'd5, 32'd22, 1'b1);
      send_item(10'd5, 32'd23, 1'b1);
      send_item(10'd9, 32'd24, 1'b1);
      send_item(10'd1, 32'd25, 1'b1);
      send_item(10'd4, 32'd26, 1'b1);
      send_item(10'd4, 32'd27, 1'b1);
      send_item(10'd4, 32'd28, 1'b1);
      send_item(10'd4, 32'd29, 1'b1);

      // A write to an unused index, then a one-entry window.
      drain();
      write_csr(CSR_SPARE_INDEX, 32'hFFFF_FFFF);
      csr_valid <= 1'b0;
      apply_setting(1, 0, 65535, 0, 1'b0);
      send_item(10'd300, 32'd40, 1'b1);
      send_item(10'd700, 32'd50, 1'b1);
      send_item(10'd200, 32'h0001_0040, 1'b1);

      // Random phases through several settings and idling patterns.
      run_phase(45, 15, 600, 0, 150, 0, 0);
      run_phase(8, 40, 100, 0, 150, 67, 0);
      run_phase(64, 200, 0, 0, 150, 0, 67);
      run_phase(1, 0, 65535, 0, 100, 6, 6);
      run_phase(3, 1023, 50, 1, 80, 0, 0);
      run_phase(100, 300, 20, 0, 120, 67, 0);
      run_phase(0, 5, 10, 1, 100, 0, 67);
      run_phase(16, 100, 250, 0, 150, 6, 6);

      // Long receiver hold-off while the sender keeps offering, so input stalls.
      run_phase(2, 50, 30, 0, 40, 0, 0);
      fork
         begin
            hold_rsp <= 1'b1;
            repeat (400) @(posedge clock);
            hold_rsp <= 1'b0;
         end
         repeat (30) offer_random();
      join

      run_phase(127, 60, 400, 1, 100, 0, 67);
      apply_setting($urandom_range(1, 64), $urandom_range(0, 400), $urandom_range(0, 2000),
                    $urandom_range(0, 1), 1'b1);
      send_idle_pct = 6;
      recv_stall_pct <= 6;
      repeat (100) offer_random();

      // Wait for the last results, bounded.
      req_valid <= 1'b0;
      waited = 0;
      while (sb.awaited_reports.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (300) @(posedge clock);
      if (sb.awaited_reports.size() != 0) begin
         sb.mismatches += sb.awaited_reports.size();
         $display("MISMATCH: %0d expected results never arrived", sb.awaited_reports.size());
      end

      $display("Covered %0d samples over %0d register settings: %0d results checked,",
               sb.samples_in, settings_used, sb.reports_seen);
      $display("%0d triggers fired and %0d window re-searches; %0d mismatches.",
               sb.fires_seen, sb.rescans, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
